@@ src/wsrq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrq_pkg: shared types for the work-stealing ready queue unit
// request and result payloads, controller states, command and status groups
// ----------------------------------------------------------------------------
package wsrq_pkg;

	// sizing, fixed by the payload field widths
	localparam int MAX_WORKERS = 8;
	localparam int DEQUE_DEPTH = 16;
	localparam int JOB_SLOTS   = 256;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic CFG_WORKER_COUNT = 1'b0;
	localparam logic CFG_STEAL_SEED   = 1'b1;

	localparam logic [30:0] MINSTD_MOD = 31'h7FFF_FFFF;
	localparam logic [15:0] MINSTD_MUL = 16'd48271;

	typedef struct packed {
		logic       op;
		logic [3:0] worker;
		logic [7:0] job;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] job_out;
		logic       was_stolen;
		logic [2:0] from_queue;
		logic       overflow;
		logic [7:0] ready_total;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RD_WAIT,
		ST_RND_MUL,
		ST_RND_RED,
		ST_RND_MOD,
		ST_SCAN,
		ST_STEAL_WAIT,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller commands into the datapath
	typedef struct packed {
		logic capture;
		logic do_push;
		logic rd_own;
		logic pop_own;
		logic rnd_mul;
		logic rnd_red;
		logic rnd_mod;
		logic scan_start;
		logic scan_step;
		logic rd_steal;
		logic finish_steal;
		logic finish_none;
	} cmd_t;

	// datapath status back to the controller
	typedef struct packed {
		logic is_pop;
		logic own_ok;
		logic mod_done;
		logic scan_hit;
		logic scan_end;
	} sts_t;

endpackage

@@ src/wsrq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrq_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module wsrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ src/wsrq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrq_ctrl: request sequencer
// steps one item through push, own pop, victim draw, scan and steal
// ----------------------------------------------------------------------------
module wsrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wsrq_pkg::sts_t    sts,
	output wsrq_pkg::cmd_t    cmd
);

	wsrq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			wsrq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = wsrq_pkg::ST_DECIDE;
				end
			end
			wsrq_pkg::ST_DECIDE: begin
				if (!sts.is_pop) begin
					cmd.do_push = 1'b1;
					state_d = wsrq_pkg::ST_OUT;
				end else if (sts.own_ok) begin
					cmd.rd_own = 1'b1;
					state_d = wsrq_pkg::ST_RD_WAIT;
				end else begin
					cmd.rnd_mul = 1'b1;
					state_d = wsrq_pkg::ST_RND_MUL;
				end
			end
			wsrq_pkg::ST_RD_WAIT: begin
				cmd.pop_own = 1'b1;
				state_d = wsrq_pkg::ST_OUT;
			end
			wsrq_pkg::ST_RND_MUL: begin
				cmd.rnd_red = 1'b1;
				state_d = wsrq_pkg::ST_RND_RED;
			end
			wsrq_pkg::ST_RND_RED: begin
				cmd.rnd_mod = 1'b1;
				state_d = wsrq_pkg::ST_RND_MOD;
			end
			wsrq_pkg::ST_RND_MOD: begin
				if (sts.mod_done) begin
					cmd.scan_start = 1'b1;
					state_d = wsrq_pkg::ST_SCAN;
				end else begin
					cmd.rnd_mod = 1'b1;
				end
			end
			wsrq_pkg::ST_SCAN: begin
				if (sts.scan_hit) begin
					cmd.rd_steal = 1'b1;
					state_d = wsrq_pkg::ST_STEAL_WAIT;
				end else if (sts.scan_end) begin
					cmd.finish_none = 1'b1;
					state_d = wsrq_pkg::ST_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			wsrq_pkg::ST_STEAL_WAIT: begin
				cmd.finish_steal = 1'b1;
				state_d = wsrq_pkg::ST_OUT;
			end
			wsrq_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = wsrq_pkg::ST_IDLE;
				end
			end
			default: state_d = wsrq_pkg::ST_IDLE;
		endcase
	end

	// a result is only offered in the output state
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == wsrq_pkg::ST_OUT)
		else $error("result offered outside output state");
	// an accepted item always moves to decide
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == wsrq_pkg::ST_DECIDE)
		else $error("accepted item not decided");
	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

endmodule

@@ src/wsrq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrq_dp: deque datapath
// deque pointers, slot ram, minstd generator, victim scan and result register
// ----------------------------------------------------------------------------
module wsrq_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [30:0]     cfg_data,
	input  wsrq_pkg::req_t  req,
	input  wsrq_pkg::cmd_t  cmd,
	output wsrq_pkg::sts_t  sts,
	output wsrq_pkg::rsp_t  rsp
);

	localparam int WW = (wsrq_pkg::MAX_WORKERS > 1) ? $clog2(wsrq_pkg::MAX_WORKERS) : 1;
	localparam int DW = (wsrq_pkg::DEQUE_DEPTH > 1) ? $clog2(wsrq_pkg::DEQUE_DEPTH) : 1;
	localparam int FW = $clog2(wsrq_pkg::DEQUE_DEPTH + 1);
	localparam int AW = $clog2(wsrq_pkg::MAX_WORKERS * wsrq_pkg::DEQUE_DEPTH);
	localparam int CW = $clog2(wsrq_pkg::MAX_WORKERS + 1);

	logic [3:0]         wcount_q;
	logic [30:0]        rnd_q;
	logic [DW-1:0]      head_q [wsrq_pkg::MAX_WORKERS];
	logic [FW-1:0]      fill_q [wsrq_pkg::MAX_WORKERS];
	logic [WW-1:0]      rr_q;
	logic [7:0]         held_q;
	wsrq_pkg::req_t     req_q;
	logic [46:0]        prod_q;
	logic [30:0]        rem_q;
	logic [4:0]         modbit_q;
	logic [WW-1:0]      victim_q;
	logic [CW-1:0]      left_q;
	logic [7:0]         rjob_q;
	logic               rstolen_q;
	logic [2:0]         rq_q;
	logic               rok_q;
	logic               rovf_q;

	logic [CW-1:0]      count;
	logic [3:0]         count4;
	logic               is_worker;
	logic [WW-1:0]      own;
	logic [5:0]         rr_rem;
	logic [WW-1:0]      rr_mod;
	logic [WW-1:0]      push_tgt;
	logic               push_full;
	logic [AW-1:0]      ram_addr;
	logic               ram_we;
	logic [7:0]         ram_wdata;
	logic [7:0]         ram_rdata;
	logic [31:0]        red_sum;
	logic [30:0]        red_val;
	logic [34:0]        mod_try;
	logic [WW-1:0]      victim_nx;
	logic [DW-1:0]      own_pos;

	// effective worker count, clamped to 1..MAX_WORKERS
	always_comb begin
		if (wcount_q == 4'd0) begin
			count4 = 4'd1;
		end else if (32'(wcount_q) > wsrq_pkg::MAX_WORKERS) begin
			count4 = 4'(wsrq_pkg::MAX_WORKERS);
		end else begin
			count4 = wcount_q;
		end
		count = CW'(count4);
	end

	// round-robin cursor reduced below the count, three compare and subtract steps
	always_comb begin
		rr_rem = 6'(rr_q);
		if (rr_rem >= (6'(count) << 2)) begin
			rr_rem = rr_rem - (6'(count) << 2);
		end
		if (rr_rem >= (6'(count) << 1)) begin
			rr_rem = rr_rem - (6'(count) << 1);
		end
		if (rr_rem >= 6'(count)) begin
			rr_rem = rr_rem - 6'(count);
		end
		rr_mod = WW'(rr_rem);
	end

	assign is_worker = 32'(req_q.worker) < 32'(count);
	assign own       = WW'(req_q.worker);
	assign push_tgt  = is_worker ? own : rr_mod;
	assign push_full = 32'(fill_q[push_tgt]) >= wsrq_pkg::DEQUE_DEPTH;
	assign own_pos   = DW'(32'(head_q[own]) + 32'(fill_q[own]) - 1);
	assign victim_nx = (32'(victim_q) + 1 >= 32'(count)) ? '0 : victim_q + 1'b1;

	// mersenne reduction of the product and one restoring modulo step
	assign red_sum = {1'b0, prod_q[30:0]} + {16'd0, prod_q[46:31]};
	assign red_val = (red_sum >= {1'b0, wsrq_pkg::MINSTD_MOD}) ?
		31'(red_sum - {1'b0, wsrq_pkg::MINSTD_MOD}) : red_sum[30:0];
	assign mod_try = {4'd0, rem_q} - (35'(count) << modbit_q);

	// slot ram address select
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = req_q.job;
		ram_addr  = '0;
		if (cmd.do_push) begin
			ram_we   = !push_full;
			ram_addr = AW'(32'(push_tgt) * wsrq_pkg::DEQUE_DEPTH
				+ ((32'(head_q[push_tgt]) + 32'(fill_q[push_tgt]))
				% wsrq_pkg::DEQUE_DEPTH));
		end else if (cmd.rd_own) begin
			ram_addr = AW'(32'(own) * wsrq_pkg::DEQUE_DEPTH + 32'(own_pos));
		end else if (cmd.rd_steal) begin
			ram_addr = AW'(32'(victim_q) * wsrq_pkg::DEQUE_DEPTH + 32'(head_q[victim_q]));
		end
	end

	wsrq_ram #(
		.WIDTH (8),
		.DEPTH (wsrq_pkg::MAX_WORKERS * wsrq_pkg::DEQUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (8'(32'(ram_wdata) % wsrq_pkg::JOB_SLOTS)),
		.rdata (ram_rdata)
	);

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.rnd_mul) begin
			prod_q <= 47'(rnd_q) * 47'(wsrq_pkg::MINSTD_MUL);
		end
		// modulo steps bits 30 down to 0; the bit counter wraps to all ones when done
		if (cmd.rnd_red) begin
			rem_q    <= red_val;
			modbit_q <= 5'd30;
		end else if (cmd.rnd_mod) begin
			if (!mod_try[34]) begin
				rem_q <= mod_try[30:0];
			end
			modbit_q <= modbit_q - 5'd1;
		end
		if (cmd.scan_start) begin
			victim_q <= WW'(rem_q);
			left_q   <= count;
		end else if (cmd.scan_step) begin
			victim_q <= victim_nx;
			left_q   <= left_q - 1'b1;
		end
	end

	// control state: config, pointers, cursor, generator, totals, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q  <= 4'd1;
			rnd_q     <= 31'd1;
			rr_q      <= '0;
			held_q    <= '0;
			rok_q     <= 1'b0;
			rjob_q    <= '0;
			rstolen_q <= 1'b0;
			rq_q      <= '0;
			rovf_q    <= 1'b0;
			for (int i = 0; i < wsrq_pkg::MAX_WORKERS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					wsrq_pkg::CFG_WORKER_COUNT: wcount_q <= cfg_data[3:0];
					wsrq_pkg::CFG_STEAL_SEED: begin
						if (cfg_data == 31'd0 || cfg_data == wsrq_pkg::MINSTD_MOD) begin
							rnd_q <= 31'd1;
						end else begin
							rnd_q <= cfg_data;
						end
					end
					default: ;
				endcase
			end
			if (cmd.rnd_red) begin
				rnd_q <= red_val;
			end
			// push
			if (cmd.do_push) begin
				if (!is_worker) begin
					rr_q <= (32'(rr_mod) + 1 >= 32'(count)) ? '0 : rr_mod + 1'b1;
				end
				rok_q     <= !push_full;
				rovf_q    <= push_full;
				rjob_q    <= '0;
				rstolen_q <= 1'b0;
				rq_q      <= 3'(push_tgt);
				if (!push_full) begin
					fill_q[push_tgt] <= fill_q[push_tgt] + 1'b1;
					held_q <= held_q + 8'd1;
				end
			end
			// own pop
			if (cmd.pop_own) begin
				fill_q[own] <= fill_q[own] - 1'b1;
				held_q    <= held_q - 8'd1;
				rok_q     <= 1'b1;
				rovf_q    <= 1'b0;
				rjob_q    <= ram_rdata;
				rstolen_q <= 1'b0;
				rq_q      <= 3'(own);
			end
			// steal
			if (cmd.finish_steal) begin
				head_q[victim_q] <= DW'((32'(head_q[victim_q]) + 1) % wsrq_pkg::DEQUE_DEPTH);
				fill_q[victim_q] <= fill_q[victim_q] - 1'b1;
				held_q    <= held_q - 8'd1;
				rok_q     <= 1'b1;
				rovf_q    <= 1'b0;
				rjob_q    <= ram_rdata;
				rstolen_q <= 1'b1;
				rq_q      <= 3'(victim_q);
			end
			if (cmd.finish_none) begin
				rok_q     <= 1'b0;
				rovf_q    <= 1'b0;
				rjob_q    <= '0;
				rstolen_q <= 1'b0;
				rq_q      <= '0;
			end
		end
	end

	// status
	assign sts.is_pop   = req_q.op == wsrq_pkg::OP_POP;
	assign sts.own_ok   = is_worker && fill_q[own] != '0;
	assign sts.mod_done = modbit_q == 5'd31;
	assign sts.scan_hit = left_q != '0 && !(32'(victim_q) == 32'(req_q.worker))
		&& fill_q[victim_q] != '0;
	assign sts.scan_end = left_q == '0 || left_q == CW'(1);

	assign rsp.ok          = rok_q;
	assign rsp.job_out     = rjob_q;
	assign rsp.was_stolen  = rstolen_q;
	assign rsp.from_queue  = rq_q;
	assign rsp.overflow    = rovf_q;
	assign rsp.ready_total = held_q;

	// generator state never sticks at zero
	a_rnd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q != 31'd0)
		else $error("generator state zero");
	// the start victim lies below the worker count
	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> 32'(victim_q) < 32'(count))
		else $error("victim out of range");
	// a push never both succeeds and overflows
	a_push_flags: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |=> !(rok_q && rovf_q))
		else $error("push flags clash");

endmodule

@@ src/work_stealing_ready_queues_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_ready_queues_unit: per-worker ready deques with stealing
// push to own or round-robin deque, pop own back or steal a random front
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     wsrq_pkg::req_t
// out       output     out_valid / out_ready   wsrq_pkg::rsp_t
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// push goes from decide to output, own pop adds an own ram read; any other
// pop runs the generator multiply, the reduction, a 31-step restoring modulo
// and the one-deque-a-cycle victim scan over the single slot ram port, which
// visits 1 to the worker count victims, plus a ram read when a job is stolen
// reset clears all deques at once; the slot ram needs no clearing
// one item at a time; the result is held until out_ready
// ----------------------------------------------------------------------------
module work_stealing_ready_queues_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wsrq_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output wsrq_pkg::rsp_t  out_data,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [30:0]     cfg_data
);

	wsrq_pkg::cmd_t cmd;
	wsrq_pkg::sts_t sts;

	// sequencer
	wsrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	wsrq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (out_data)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the work-stealing ready queue unit
// directed table then random push/pop traffic, each result compared with a
// behavioural deque model; random gaps on both channels and one long stall
// ----------------------------------------------------------------------------
module tb;

	localparam int NW = 8;
	localparam int DEPTH = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wsrq_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wsrq_pkg::rsp_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [30:0] cfg_data = '0;

	work_stealing_ready_queues_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// deque model state
	logic [7:0] slot_mem [NW][DEPTH];
	int unsigned head_q [NW];
	int unsigned fill_q [NW];
	int unsigned rr_cursor;
	int unsigned lcg_state;
	int unsigned held_total;
	logic [3:0] wcount_reg;

	wsrq_pkg::rsp_t pending_rsp [$];
	int mismatches = 0;
	int unsigned stall_cycles = 0;
	int hold_req = 0;
	int hold_seen = 0;
	bit stimulus_done = 1'b0;

	function automatic int unsigned seed_fix(logic [30:0] s);
		int unsigned v;
		v = s % 32'h7FFF_FFFF;
		return (v == 0) ? 1 : v;
	endfunction

	function automatic int unsigned active_workers();
		if (wcount_reg == 0) return 1;
		if (wcount_reg > NW) return NW;
		return wcount_reg;
	endfunction

	// work out one result and advance the model
	function automatic wsrq_pkg::rsp_t schedule_req(wsrq_pkg::req_t r);
		wsrq_pkg::rsp_t o;
		int unsigned cnt, tgt, start, v;
		longint unsigned prod;
		o = '0;
		cnt = active_workers();
		if (r.op == wsrq_pkg::OP_PUSH) begin
			tgt = r.worker;
			if (tgt >= cnt) begin
				tgt = rr_cursor % cnt;
				rr_cursor = (tgt + 1) % cnt;
			end
			o.from_queue = tgt[2:0];
			if (fill_q[tgt] >= DEPTH) begin
				o.overflow = 1'b1;
			end else begin
				slot_mem[tgt][(head_q[tgt] + fill_q[tgt]) % DEPTH] = r.job;
				fill_q[tgt]++;
				held_total++;
				o.ok = 1'b1;
			end
			o.ready_total = held_total[7:0];
			return o;
		end
		if (r.worker < cnt && fill_q[r.worker] != 0) begin
			o.job_out = slot_mem[r.worker][(head_q[r.worker] + fill_q[r.worker] - 1) % DEPTH];
			fill_q[r.worker]--;
			held_total--;
			o.ok = 1'b1;
			o.from_queue = r.worker[2:0];
			o.ready_total = held_total[7:0];
			return o;
		end
		prod = longint'(lcg_state) * 48271;
		lcg_state = prod % 64'h7FFF_FFFF;
		start = lcg_state % cnt;
		for (int i = 0; i < cnt; i++) begin
			v = (start + i) % cnt;
			if (v == r.worker || fill_q[v] == 0) continue;
			o.job_out = slot_mem[v][head_q[v]];
			head_q[v] = (head_q[v] + 1) % DEPTH;
			fill_q[v]--;
			held_total--;
			o.ok = 1'b1;
			o.was_stolen = 1'b1;
			o.from_queue = v[2:0];
			break;
		end
		o.ready_total = held_total[7:0];
		return o;
	endfunction

	task automatic send_req(wsrq_pkg::req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
		if ($urandom_range(0, 3) == 0) gap = 1;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		pending_rsp.insert(pending_rsp.size(), schedule_req(r));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [30:0] val);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == wsrq_pkg::CFG_WORKER_COUNT) wcount_reg = val[3:0];
		else lcg_state = seed_fix(val);
	endtask

	// receiver with random back-pressure and an optional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			stall_cycles <= 400;
			out_ready <= 1'b0;
		end else if (stall_cycles != 0) begin
			stall_cycles <= stall_cycles - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 19) == 0) begin
			stall_cycles <= $urandom_range(5, 40);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		wsrq_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %p", out_data);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end
	end

	typedef struct {
		wsrq_pkg::req_t rq;
		bit             known;
		wsrq_pkg::rsp_t res;
	} dir_row_t;

	initial begin
		dir_row_t rows [$];
		wsrq_pkg::req_t r;
		wsrq_pkg::rsp_t x;
		int unsigned w;
		for (int q = 0; q < NW; q++) begin
			head_q[q] = 0;
			fill_q[q] = 0;
		end
		rr_cursor = 0;
		lcg_state = 1;
		held_total = 0;
		wcount_reg = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty after reset, then pushes and pops
		x = '0;
		rows.insert(rows.size(), '{'{wsrq_pkg::OP_POP, 4'd0, 8'd0}, 1'b1, x});
		x = '0; x.ok = 1; x.ready_total = 1;
		rows.insert(rows.size(), '{'{wsrq_pkg::OP_PUSH, 4'd0, 8'd255}, 1'b1, x});
		x = '0; x.ok = 1; x.job_out = 255;
		rows.insert(rows.size(), '{'{wsrq_pkg::OP_POP, 4'd0, 8'd0}, 1'b1, x});
		rows.insert(rows.size(), '{'{wsrq_pkg::OP_PUSH, 4'd15, 8'd0}, 1'b0, x});
		rows.insert(rows.size(), '{'{wsrq_pkg::OP_POP, 4'd8, 8'd0}, 1'b0, x});
		foreach (rows[i]) begin
			send_req(rows[i].rq);
			if (rows[i].known && pending_rsp[$] !== rows[i].res) begin
				mismatches++;
				$display("table row %0d: model disagrees with expected", i);
			end
		end

		// count above the maximum, steals and overflow
		write_reg(wsrq_pkg::CFG_WORKER_COUNT, 31'd15);
		write_reg(wsrq_pkg::CFG_STEAL_SEED, 31'h7FFF_FFFF);
		for (int i = 0; i < 17; i++) send_req('{wsrq_pkg::OP_PUSH, 4'd3, 8'(i)});
		send_req('{wsrq_pkg::OP_POP, 4'd3, 8'd0});
		send_req('{wsrq_pkg::OP_POP, 4'd1, 8'd0});
		send_req('{wsrq_pkg::OP_POP, 4'd12, 8'd0});

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(wsrq_pkg::CFG_WORKER_COUNT, 31'd0);
				1: write_reg(wsrq_pkg::CFG_WORKER_COUNT, 31'd8);
				2: write_reg(wsrq_pkg::CFG_WORKER_COUNT, 31'd1);
				3: write_reg(wsrq_pkg::CFG_WORKER_COUNT, 31'(4'($urandom_range(2, 7))));
				4: write_reg(wsrq_pkg::CFG_STEAL_SEED, 31'd0);
				default: write_reg(wsrq_pkg::CFG_STEAL_SEED, 31'($urandom));
			endcase
			if (ph == 3) hold_req++;
			for (int i = 0; i < 120; i++) begin
				w = (wcount_reg == 0) ? 1 : wcount_reg;
				r.op = ($urandom_range(0, 99) < 55) ? wsrq_pkg::OP_PUSH : wsrq_pkg::OP_POP;
				r.worker = ($urandom_range(0, 5) == 0) ? 4'($urandom) :
					4'($urandom_range(0, (w > 8 ? 8 : w)));
				r.job = 8'($urandom);
				send_req(r);
			end
		end

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: FAIL");
		$finish;
	end
endmodule

@@ files.f @@
src/wsrq_pkg.sv
src/wsrq_ram.sv
src/wsrq_ctrl.sv
src/wsrq_dp.sv
src/work_stealing_ready_queues_unit.sv
tb/tb.sv
